/* src/ipd_pkg.sv */
package ipd_pkg;

  localparam int NUM_CFG = 8;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int BYTE_W = 8;
  localparam int NUM_BYTES = 4;

  typedef enum logic [1:0] {
    REQ_DATA    = 2'd0,
    REQ_LEADER  = 2'd1,
    REQ_TIMEOUT = 2'd2
  } req_type_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 3'd7;

  typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = {
    16'd2300, 16'd2200, 16'd1400, 16'd1100,
    16'd4600, 16'd4400, 16'd9050, 16'd8950
  };

  // window hits for one interval
  typedef struct packed {
    logic leader;
    logic space;
    logic zero;
    logic one;
  } win_hits_t;

  localparam logic [BYTE_W-1:0] MASK_NIB  = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_PAIR = 8'hCC;
  localparam logic [BYTE_W-1:0] MASK_ODD  = 8'hAA;

  function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] x;
    x = ((v & MASK_NIB) >> 4) | ((v & ~MASK_NIB) << 4);
    x = ((x & MASK_PAIR) >> 2) | ((x & ~MASK_PAIR) << 2);
    x = ((x & MASK_ODD) >> 1) | ((x & ~MASK_ODD) << 1);
    return x;
  endfunction

endpackage

/* src/ir_pulse_distance_decoder_unit.sv */
// Pulse-distance IR frame decoder.
//
// Request channel (req_valid/req_stall) carries edge events: req_type selects
// data edge, leader edge or frame timeout, interval_ticks is the time since
// the previous edge. Only a timeout produces a transaction on the result
// channel (rsp_valid/rsp_stall): the four received bytes, bit-reversed, and
// the leader burst and leader space flags.
//
// One event is accepted per cycle while req_stall is low. An event is registered on
// acceptance and evaluated against the frame state when it fires; a timeout also
// loads the result register, which holds the result until it is taken.
// A stalled result blocks the request side only when the next registered
// event is itself a timeout; other events keep flowing.
//
// Window registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready, and should change only while the decoder is idle.
// Reset (rst, synchronous) restores the default windows, clears the frame
// state, re-arms the leader and empties both pipeline registers.
module ir_pulse_distance_decoder_unit import ipd_pkg::*; #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            req_type,
  input  logic [TICK_WIDTH-1:0] interval_ticks,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [BYTE_W-1:0]     address,
  output logic [BYTE_W-1:0]     address_cpl,
  output logic [BYTE_W-1:0]     command,
  output logic [BYTE_W-1:0]     command_cpl,
  output logic                  leader_ok,
  output logic                  space_ok,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_regs_t cfg;

  logic                  ev_valid;
  logic [1:0]            ev_type;
  logic [TICK_WIDTH-1:0] ev_ticks;
  logic                  ev_fire;
  logic                  ev_timeout;

  logic [1:0] edge_count, edge_count_next;
  logic [5:0] bit_index, bit_index_next;
  logic       leader_armed, leader_armed_next;
  logic       leader_seen, leader_seen_next;
  logic       space_seen, space_seen_next;
  logic [NUM_BYTES-1:0][BYTE_W-1:0] frame_bytes, frame_bytes_next;

  logic [1:0] edge_bumped;
  logic [1:0] byte_sel;
  win_hits_t  hits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  ipd_classify #(.TICK_WIDTH(TICK_WIDTH)) u_classify (
    .ticks (ev_ticks),
    .cfg   (cfg),
    .hits  (hits)
  );

  assign ev_timeout = (ev_type == REQ_TIMEOUT);
  // only a timeout needs the result register
  assign ev_fire   = ev_valid && !(ev_timeout && rsp_valid && rsp_stall);
  assign req_stall = ev_valid && !ev_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      ev_valid <= 1'b1;
    end else if (ev_fire) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      ev_type  <= req_type;
      ev_ticks <= interval_ticks;
    end
  end

  assign edge_bumped = (edge_count == 2'd3) ? edge_count : edge_count + 2'd1;
  assign byte_sel    = bit_index[4:3];

  always_comb begin
    edge_count_next   = edge_count;
    bit_index_next    = bit_index;
    leader_armed_next = leader_armed;
    leader_seen_next  = leader_seen;
    space_seen_next   = space_seen;
    frame_bytes_next  = frame_bytes;
    if (ev_fire) begin
      case (ev_type)
        REQ_LEADER: begin
          if (leader_armed) begin
            edge_count_next   = edge_bumped;
            leader_armed_next = 1'b0;
            if (hits.leader) leader_seen_next = 1'b1;
          end
        end
        REQ_DATA: begin
          // first edge only starts timing
          if (edge_count != 2'd0) begin
            edge_count_next = edge_bumped;
            if (edge_bumped == 2'd2 && hits.space) space_seen_next = 1'b1;
            if (leader_seen && space_seen && edge_bumped == 2'd3 && !bit_index[5]) begin
              if (hits.zero) begin
                frame_bytes_next[byte_sel] = {frame_bytes[byte_sel][BYTE_W-2:0], 1'b0};
              end else if (hits.one) begin
                frame_bytes_next[byte_sel] = {frame_bytes[byte_sel][BYTE_W-2:0], 1'b1};
              end
              bit_index_next = bit_index + 6'd1;
            end
          end
        end
        REQ_TIMEOUT: begin
          edge_count_next   = '0;
          bit_index_next    = '0;
          leader_armed_next = 1'b1;
          leader_seen_next  = 1'b0;
          space_seen_next   = 1'b0;
          frame_bytes_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count   <= '0;
      bit_index    <= '0;
      leader_armed <= 1'b1;
      leader_seen  <= 1'b0;
      space_seen   <= 1'b0;
      frame_bytes  <= '0;
    end else begin
      edge_count   <= edge_count_next;
      bit_index    <= bit_index_next;
      leader_armed <= leader_armed_next;
      leader_seen  <= leader_seen_next;
      space_seen   <= space_seen_next;
      frame_bytes  <= frame_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ev_fire && ev_timeout) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_fire && ev_timeout) begin
      address     <= reverse8(frame_bytes[0]);
      address_cpl <= reverse8(frame_bytes[1]);
      command     <= reverse8(frame_bytes[2]);
      command_cpl <= reverse8(frame_bytes[3]);
      leader_ok   <= leader_seen;
      space_ok    <= space_seen;
    end
  end

endmodule

/* src/ipd_classify.sv */
module ipd_classify import ipd_pkg::*; #(
  parameter int TICK_WIDTH = 16
) (
  input  logic [TICK_WIDTH-1:0] ticks,
  input  cfg_regs_t             cfg,
  output win_hits_t             hits
);

  localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

  logic [CMP_W-1:0] t_ext;
  logic [NUM_CFG-1:0][CMP_W-1:0] bound;

  assign t_ext = CMP_W'(ticks);

  always_comb begin
    for (int i = 0; i < NUM_CFG; i++) begin
      bound[i] = CMP_W'(cfg[i]);
    end
  end

  // all windows are open at both ends
  assign hits.leader = (t_ext > bound[CFG_LEADER_MIN]) && (t_ext < bound[CFG_LEADER_MAX]);
  assign hits.space  = (t_ext > bound[CFG_SPACE_MIN])  && (t_ext < bound[CFG_SPACE_MAX]);
  assign hits.zero   = (t_ext > bound[CFG_ZERO_MIN])   && (t_ext < bound[CFG_ZERO_MAX]);
  assign hits.one    = (t_ext > bound[CFG_ONE_MIN])    && (t_ext < bound[CFG_ONE_MAX]);

endmodule

/* src/ipd_checker.sv */
module ipd_checker import ipd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [BYTE_W-1:0] address,
  input logic [BYTE_W-1:0] address_cpl,
  input logic [BYTE_W-1:0] command,
  input logic [BYTE_W-1:0] command_cpl,
  input logic              leader_ok,
  input logic              space_ok
);

  // reset empties both pipeline registers
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid && !req_stall)
    else $error("pipeline not empty after reset");

  // request side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a pending result");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable({address, address_cpl, command, command_cpl,
                                        leader_ok, space_ok}))
    else $error("result changed while stalled");

endmodule

bind ir_pulse_distance_decoder_unit ipd_checker u_ipd_checker (.*);

/* tb/sv/ir_pulse_distance_decoder_checker.sv */
module ir_pulse_distance_decoder_checker import ipd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic [1:0]        req_type,
  input  logic [15:0]       interval_ticks,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [BYTE_W-1:0] address,
  input  logic [BYTE_W-1:0] address_cpl,
  input  logic [BYTE_W-1:0] command,
  input  logic [BYTE_W-1:0] command_cpl,
  input  logic              leader_ok,
  input  logic              space_ok,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending_frames,
  output int                frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;
  localparam int FRAME_BITS = 32;

  typedef struct packed {
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] address_cpl;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] command_cpl;
    logic              leader_ok;
    logic              space_ok;
  } frame_word_t;

  frame_word_t      frames_due[$];
  logic [CFG_W-1:0] windows [NUM_CFG];

  // decoder state mirror
  logic [1:0]        edges;
  logic [5:0]        bits_taken;
  logic              armed;
  logic              leader_hit;
  logic              space_hit;
  logic [BYTE_W-1:0] rx_bytes [NUM_BYTES];

  function automatic logic hit(input logic [15:0] t, input logic [CFG_W-1:0] lo,
                               input logic [CFG_W-1:0] hi);
    return (t > lo) && (t < hi);
  endfunction

  function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) r[i] = v[BYTE_W-1-i];
    return r;
  endfunction

  task automatic clear_frame_state();
    edges = '0;
    bits_taken = '0;
    armed = 1'b1;
    leader_hit = 1'b0;
    space_hit = 1'b0;
    for (int i = 0; i < NUM_BYTES; i++) rx_bytes[i] = '0;
  endtask

  task automatic decode_event(input logic [1:0] kind, input logic [15:0] t);
    frame_word_t w;
    logic [1:0]  slot;
    case (kind)
      REQ_LEADER: begin
        if (armed) begin
          if (edges != 2'd3) edges++;
          if (hit(t, windows[CFG_LEADER_MIN], windows[CFG_LEADER_MAX])) leader_hit = 1'b1;
          armed = 1'b0;
        end
      end
      REQ_DATA: begin
        // first edge only starts timing
        if (edges != 2'd0) begin
          if (edges != 2'd3) edges++;
          if (edges == 2'd2 && hit(t, windows[CFG_SPACE_MIN], windows[CFG_SPACE_MAX]))
            space_hit = 1'b1;
          if (leader_hit && space_hit && edges == 2'd3 && bits_taken < FRAME_BITS) begin
            slot = bits_taken[4:3];
            if (hit(t, windows[CFG_ZERO_MIN], windows[CFG_ZERO_MAX]))
              rx_bytes[slot] = {rx_bytes[slot][BYTE_W-2:0], 1'b0};
            else if (hit(t, windows[CFG_ONE_MIN], windows[CFG_ONE_MAX]))
              rx_bytes[slot] = {rx_bytes[slot][BYTE_W-2:0], 1'b1};
            bits_taken++;
          end
        end
      end
      REQ_TIMEOUT: begin
        w.address     = flip_byte(rx_bytes[0]);
        w.address_cpl = flip_byte(rx_bytes[1]);
        w.command     = flip_byte(rx_bytes[2]);
        w.command_cpl = flip_byte(rx_bytes[3]);
        w.leader_ok   = leader_hit;
        w.space_ok    = space_hit;
        frames_due.push_back(w);
        clear_frame_state();
      end
      default: ;
    endcase
  endtask

  task automatic check_frame();
    frame_word_t got;
    frame_word_t want;
    got = '{address, address_cpl, command, command_cpl, leader_ok, space_ok};
    if (frames_due.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("[%0t] unexpected frame: addr %02h/%02h cmd %02h/%02h lead %0b space %0b",
                 $realtime, got.address, got.address_cpl, got.command, got.command_cpl,
                 got.leader_ok, got.space_ok);
    end else begin
      want = frames_due.pop_front();
      frames_checked++;
      if (got.address !== want.address || got.address_cpl !== want.address_cpl ||
          got.command !== want.command || got.command_cpl !== want.command_cpl ||
          got.leader_ok !== want.leader_ok || got.space_ok !== want.space_ok) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("[%0t] frame mismatch: exp addr %02h/%02h cmd %02h/%02h lead %0b space %0b",
                   $realtime, want.address, want.address_cpl, want.command,
                   want.command_cpl, want.leader_ok, want.space_ok);
          $display("    got addr %02h/%02h cmd %02h/%02h lead %0b space %0b",
                   got.address, got.address_cpl, got.command, got.command_cpl,
                   got.leader_ok, got.space_ok);
        end
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending_frames = 0;
    frames_checked = 0;
    clear_frame_state();
    for (int i = 0; i < NUM_CFG; i++) windows[i] = CFG_RESET[i];
  end

  always @(posedge clk) begin
    if (rst) begin
      frames_due.delete();
      clear_frame_state();
      for (int i = 0; i < NUM_CFG; i++) windows[i] = CFG_RESET[i];
    end else begin
      if (cfg_valid && cfg_ready) windows[cfg_index] = cfg_data;
      // results trail requests through the event and result registers, so the older expectation goes first
      if (rsp_valid && !rsp_stall) check_frame();
      if (req_valid && !req_stall) decode_event(req_type, interval_ticks);
    end
    pending_frames = frames_due.size();
  end

endmodule

/* tb/sv/ir_pulse_distance_decoder_unit_tb.sv */
module ir_pulse_distance_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipd_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [1:0]           req_type;
  logic [15:0]          interval_ticks;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic [BYTE_W-1:0]    address;
  logic [BYTE_W-1:0]    address_cpl;
  logic [BYTE_W-1:0]    command;
  logic [BYTE_W-1:0]    command_cpl;
  logic                 leader_ok;
  logic                 space_ok;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending_frames;
  int frames_checked;
  int events_sent;
  int window_sets;
  int quiet_cycles;
  bit req_gaps_on;
  bit rsp_gaps_on;

  logic [CFG_W-1:0] win [NUM_CFG];

  ir_pulse_distance_decoder_unit #(.TICK_WIDTH(16)) DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .interval_ticks(interval_ticks),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .address(address), .address_cpl(address_cpl),
    .command(command), .command_cpl(command_cpl),
    .leader_ok(leader_ok), .space_ok(space_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ir_pulse_distance_decoder_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .interval_ticks(interval_ticks),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .address(address), .address_cpl(address_cpl),
    .command(command), .command_cpl(command_cpl),
    .leader_ok(leader_ok), .space_ok(space_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_frames(pending_frames),
    .frames_checked(frames_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: stall is raised ahead of a result and held for a drawn number of cycles
  initial begin
    int hold;
    rsp_stall = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      hold = rsp_gaps_on ? $urandom_range(0, 8) : 0;
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        do @(posedge clk); while (!rsp_valid);
        repeat (hold - 1) @(posedge clk);
        @(negedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  function automatic logic [15:0] any_ticks();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_inside(input logic [CFG_W-1:0] lo,
                                              input logic [CFG_W-1:0] hi);
    if (hi > lo + 1) return 16'($urandom_range(lo + 1, hi - 1));
    return any_ticks();
  endfunction

  function automatic logic [15:0] pick_outside(input logic [CFG_W-1:0] lo,
                                               input logic [CFG_W-1:0] hi);
    logic [15:0] v;
    v = any_ticks();
    // the lower bound itself is never inside a strict window
    if (v > lo && v < hi) v = lo;
    return v;
  endfunction

  // called at a falling edge; leaves req_valid high after the transaction
  task automatic send_event(input logic [1:0] kind, input logic [15:0] ticks);
    int gap;
    gap = req_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    interval_ticks <= ticks;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    events_sent++;
  endtask

  // sender holds off until every frame has come back and the pipeline drained
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_frames != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_windows();
    settle();
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= win[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    window_sets++;
  endtask

  task automatic random_pair(input logic [CFG_IDX_W-1:0] lo_idx,
                             input logic [CFG_IDX_W-1:0] hi_idx, input int span);
    int lo;
    int hi;
    lo = $urandom_range(0, 16'hFFFF);
    hi = lo + $urandom_range(2, span);
    if (hi > 16'hFFFF) hi = 16'hFFFF;
    win[lo_idx] = lo[15:0];
    win[hi_idx] = hi[15:0];
  endtask

  task automatic random_windows(input int span);
    random_pair(CFG_LEADER_MIN, CFG_LEADER_MAX, span);
    random_pair(CFG_SPACE_MIN, CFG_SPACE_MAX, span);
    random_pair(CFG_ZERO_MIN, CFG_ZERO_MAX, span);
    random_pair(CFG_ONE_MIN, CFG_ONE_MAX, span);
  endtask

  task automatic send_bit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_event(REQ_DATA, pick_inside(win[CFG_ZERO_MIN], win[CFG_ZERO_MAX]));
    else if (pick < 90)
      send_event(REQ_DATA, pick_inside(win[CFG_ONE_MIN], win[CFG_ONE_MAX]));
    else if (pick < 95)
      send_event(REQ_DATA, pick_outside(win[CFG_ZERO_MIN], win[CFG_ZERO_MAX]));
    else
      send_event(REQ_DATA, any_ticks());
  endtask

  task automatic send_frame();
    int style;
    int nbits;
    style = $urandom_range(0, 99);
    req_gaps_on = ($urandom_range(0, 3) != 0);
    rsp_gaps_on = ($urandom_range(0, 3) != 0);
    if (style < 70) begin
      // well-formed frame, a few with missed windows or extra/missing bits
      send_event(REQ_LEADER, ($urandom_range(0, 19) == 0) ?
                 pick_outside(win[CFG_LEADER_MIN], win[CFG_LEADER_MAX]) :
                 pick_inside(win[CFG_LEADER_MIN], win[CFG_LEADER_MAX]));
      send_event(REQ_DATA, ($urandom_range(0, 19) == 0) ?
                 pick_outside(win[CFG_SPACE_MIN], win[CFG_SPACE_MAX]) :
                 pick_inside(win[CFG_SPACE_MIN], win[CFG_SPACE_MAX]));
      nbits = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 36) : 32;
      for (int i = 0; i < nbits; i++) begin
        if ($urandom_range(0, 39) == 0)
          send_event($urandom_range(0, 3) == 0 ? REQ_LEADER : REQ_UNUSED, any_ticks());
        send_bit();
      end
      send_event(REQ_TIMEOUT, any_ticks());
    end else if (style < 85) begin
      // broken frame: random leader parts, maybe no leader at all, truncated
      if ($urandom_range(0, 2) != 0)
        send_event(REQ_LEADER, any_ticks());
      send_event(REQ_DATA, any_ticks());
      nbits = $urandom_range(0, 20);
      for (int i = 0; i < nbits; i++) send_bit();
      send_event(REQ_TIMEOUT, any_ticks());
    end else begin
      nbits = $urandom_range(5, 15);
      for (int i = 0; i < nbits; i++)
        send_event(2'($urandom_range(0, 3)), any_ticks());
      if ($urandom_range(0, 1) == 1) send_event(REQ_TIMEOUT, any_ticks());
    end
    if ($urandom_range(0, 9) == 0) settle();
  endtask

  task automatic run_frames(input int target);
    while (events_sent < target) send_frame();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_DATA;
    interval_ticks = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    events_sent = 0;
    window_sets = 0;
    quiet_cycles = 0;
    req_gaps_on = 1'b0;
    rsp_gaps_on = 1'b0;
    for (int i = 0; i < NUM_CFG; i++) win[i] = CFG_RESET[i];
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, default windows, back-to-back
    send_event(REQ_DATA, 16'hFFFF);      // lone first edge, ignored
    send_event(REQ_TIMEOUT, 16'h0000);   // empty frame
    send_event(REQ_UNUSED, 16'hFFFF);
    send_event(REQ_LEADER, 16'd9000);
    send_event(REQ_LEADER, 16'hFFFF);    // disarmed, ignored
    send_event(REQ_DATA, 16'd4500);
    send_event(REQ_DATA, 16'd1250);
    send_event(REQ_DATA, 16'd2250);
    send_event(REQ_DATA, 16'd1100);      // window edges are excluded
    send_event(REQ_DATA, 16'd2300);
    send_event(REQ_DATA, 16'h0000);
    send_event(REQ_DATA, 16'hFFFF);
    send_event(REQ_TIMEOUT, 16'hFFFF);
    send_event(REQ_LEADER, 16'd8950);    // leader just outside
    send_event(REQ_DATA, 16'd4600);
    send_event(REQ_DATA, 16'd2250);      // no bits taken without leader
    send_event(REQ_TIMEOUT, 16'h5555);
    send_event(REQ_LEADER, 16'd9049);
    send_event(REQ_DATA, 16'd4401);
    send_event(REQ_DATA, 16'd1101);
    send_event(REQ_DATA, 16'd2299);
    send_event(REQ_TIMEOUT, 16'hAAAA);

    run_frames(500);

    random_windows(3000);
    program_windows();
    run_frames(900);

    // wide open windows, zero and one overlap
    for (int i = 0; i < NUM_CFG; i += 2) begin
      win[i] = 16'h0000;
      win[i + 1] = 16'hFFFF;
    end
    program_windows();
    run_frames(1150);

    // inverted windows: nothing can match
    for (int i = 0; i < NUM_CFG; i += 2) begin
      win[i] = 16'hFFFF;
      win[i + 1] = 16'h0000;
    end
    program_windows();
    run_frames(1300);

    random_windows(40);
    program_windows();
    run_frames(1700);

    req_valid <= 1'b0;
    while (pending_frames != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d edge events under %0d window settings; %0d frames decoded and compared.",
             events_sent, window_sets + 1, frames_checked);
    $display("Stalls and gaps were applied on both channels, with quiet stretches between.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ipd_pkg.sv
src/ipd_classify.sv
src/ir_pulse_distance_decoder_unit.sv
src/ipd_checker.sv
tb/sv/ir_pulse_distance_decoder_checker.sv
tb/sv/ir_pulse_distance_decoder_unit_tb.sv
